/* hdl/mfq_pkg.sv */
// ----------------------------------------------------------------------------
// mfq_pkg
// shared widths, codes and the stored message layout of the message queue
// ----------------------------------------------------------------------------
`default_nettype none

package mfq_pkg;

  localparam int DATA_W          = 32;
  localparam int ACT_W           = 3;
  localparam int ST_W            = 2;
  localparam int OCC_W           = 7;
  localparam int CFG_W           = 16;
  localparam int DEF_QUEUE_DEPTH = 64;

  localparam logic [ACT_W-1:0] ACT_PUT    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_GET    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_FLUSH  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_ABORT  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_START  = 3'd5;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_ABORTED = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] msg_type;
    logic signed [DATA_W-1:0] arg_one;
    logic signed [DATA_W-1:0] arg_two;
  } entry_t;

endpackage

`default_nettype wire

/* hdl/mfq_if.sv */
// ----------------------------------------------------------------------------
// mfq channel interfaces
// valid/ready channels for command beats, result beats and configuration
// ----------------------------------------------------------------------------
`default_nettype none

interface mfq_in_if;
  import mfq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic signed [DATA_W-1:0] msg_type;
  logic signed [DATA_W-1:0] arg_one;
  logic signed [DATA_W-1:0] arg_two;
  modport source (output valid, action, msg_type, arg_one, arg_two, input ready);
  modport sink   (input valid, action, msg_type, arg_one, arg_two, output ready);
endinterface

interface mfq_out_if;
  import mfq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [ST_W-1:0]          status;
  logic signed [DATA_W-1:0] out_type;
  logic signed [DATA_W-1:0] out_arg_one;
  logic signed [DATA_W-1:0] out_arg_two;
  logic [OCC_W-1:0]         occupancy;
  modport source (output valid, status, out_type, out_arg_one, out_arg_two, occupancy,
                  input ready);
  modport sink   (input valid, status, out_type, out_arg_one, out_arg_two, occupancy,
                  output ready);
endinterface

interface mfq_cfg_if;
  import mfq_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

/* hdl/mfq_store.sv */
// ----------------------------------------------------------------------------
// mfq_store
// message memory, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module mfq_store
  import mfq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int AW          = $clog2(QUEUE_DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output      entry_t        rd_data
);

  entry_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* hdl/message_fifo_with_type_removal_top.sv */
// ----------------------------------------------------------------------------
// message_fifo_with_type_removal_top
// ordered message queue with abort flag and removal of all messages of a type
// ----------------------------------------------------------------------------
// put, flush, abort, start and refused beats: registered result in the cycle after accept
// get that pops: the registered memory read, then state S_GET, then the result register
// remove: reads and compacts the queue in state S_RM; one entry read per cycle
// one beat in work at a time; the next beat is taken as the result leaves
// reset: queue empty, abort flag set, flush code 0; memory is not cleared
`default_nettype none

module message_fifo_with_type_removal_top
  import mfq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mfq_in_if.sink     in_ch,
  mfq_out_if.source  out_ch,
  mfq_cfg_if.sink    cfg_ch
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_GET, S_RM} state_t;

  function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
    next_idx = (i == AW'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  state_t                   state_r;
  logic [AW-1:0]            head_r, tail_r;
  logic [CW-1:0]            count_r;
  logic                     aborted_r;
  logic [CFG_W-1:0]         flush_code_r;

  logic [AW-1:0]            rd_r, wr_r;
  logic [CW-1:0]            left_r, kept_r;
  logic                     pend_r;
  logic signed [DATA_W-1:0] rm_type_r;

  logic                     out_valid_r;
  status_t                  out_status_r;
  entry_t                   out_msg_r;
  logic [OCC_W-1:0]         out_occ_r;

  logic                     in_fire, full, keep;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr, rd_addr;
  entry_t                   wr_data, rd_data, flush_msg, in_msg;

  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign full = (count_r == CW'(QUEUE_DEPTH));
  assign keep = (rd_data.msg_type != rm_type_r);

  assign flush_msg = '{msg_type: {{(DATA_W-CFG_W){1'b0}}, flush_code_r},
                       arg_one: '0, arg_two: '0};
  assign in_msg    = '{msg_type: in_ch.msg_type, arg_one: in_ch.arg_one,
                       arg_two: in_ch.arg_two};

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = tail_r;
    wr_data = in_msg;
    if (state_r == S_RM) begin
      wr_en   = pend_r && keep;
      wr_addr = wr_r;
      wr_data = rd_data;
    end else if (in_fire && !full) begin
      if (in_ch.action == ACT_PUT) begin
        wr_en = !aborted_r;
      end else if (in_ch.action == ACT_START) begin
        wr_en   = 1'b1;
        wr_data = flush_msg;
      end
    end
  end

  assign rd_addr = (state_r == S_RM) ? rd_r : head_r;

  mfq_store #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .AW          (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
      aborted_r    <= 1'b1;
      flush_code_r <= '0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        flush_code_r <= cfg_ch.data;
      end
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            out_valid_r  <= 1'b1;
            out_status_r <= ST_OK;
            out_msg_r    <= '0;
            out_occ_r    <= OCC_W'(count_r);
            unique case (in_ch.action)
              ACT_PUT: begin
                if (aborted_r) begin
                  out_status_r <= ST_ABORTED;
                end else if (full) begin
                  out_status_r <= ST_FULL;
                end else begin
                  tail_r    <= next_idx(tail_r);
                  count_r   <= count_r + 1'b1;
                  out_occ_r <= OCC_W'(count_r + 1'b1);
                end
              end
              ACT_GET: begin
                if (aborted_r) begin
                  out_status_r <= ST_ABORTED;
                end else if (count_r == '0) begin
                  out_status_r <= ST_EMPTY;
                end else begin
                  head_r      <= next_idx(head_r);
                  count_r     <= count_r - 1'b1;
                  out_valid_r <= 1'b0;
                  state_r     <= S_GET;
                end
              end
              ACT_FLUSH: begin
                head_r    <= '0;
                tail_r    <= '0;
                count_r   <= '0;
                out_occ_r <= '0;
              end
              ACT_REMOVE: begin
                if (aborted_r) begin
                  out_status_r <= ST_ABORTED;
                end else begin
                  rd_r        <= head_r;
                  wr_r        <= head_r;
                  left_r      <= count_r;
                  kept_r      <= '0;
                  pend_r      <= 1'b0;
                  rm_type_r   <= in_ch.msg_type;
                  out_valid_r <= 1'b0;
                  state_r     <= S_RM;
                end
              end
              ACT_ABORT: begin
                aborted_r <= 1'b1;
              end
              ACT_START: begin
                aborted_r <= 1'b0;
                if (full) begin
                  out_status_r <= ST_FULL;
                end else begin
                  tail_r    <= next_idx(tail_r);
                  count_r   <= count_r + 1'b1;
                  out_occ_r <= OCC_W'(count_r + 1'b1);
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_GET: begin
          out_valid_r  <= 1'b1;
          out_status_r <= ST_OK;
          out_msg_r    <= rd_data;
          out_occ_r    <= OCC_W'(count_r);
          state_r      <= S_IDLE;
        end
        S_RM: begin
          if (left_r != '0) begin
            rd_r   <= next_idx(rd_r);
            left_r <= left_r - 1'b1;
            pend_r <= 1'b1;
          end else begin
            pend_r <= 1'b0;
          end
          if (pend_r && keep) begin
            wr_r   <= next_idx(wr_r);
            kept_r <= kept_r + 1'b1;
          end
          if (left_r == '0 && !pend_r) begin
            tail_r       <= wr_r;
            count_r      <= kept_r;
            out_valid_r  <= 1'b1;
            out_status_r <= ST_OK;
            out_msg_r    <= '0;
            out_occ_r    <= OCC_W'(kept_r);
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.out_type    = out_msg_r.msg_type;
  assign out_ch.out_arg_one = out_msg_r.arg_one;
  assign out_ch.out_arg_two = out_msg_r.arg_two;
  assign out_ch.occupancy   = out_occ_r;

  // count never exceeds capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  // popped message is presented in the cycle after S_GET
  a_get_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_GET |=> out_valid_r && state_r == S_IDLE)
    else $error("get result not delivered");

  // no memory write while a pop read is in flight
  a_get_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_GET |-> !wr_en)
    else $error("memory write during get");

  // compaction keeps no more entries than the queue held
  a_rm_kept: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RM |-> kept_r <= count_r)
    else $error("remove kept more entries than stored");

endmodule

`default_nettype wire
